FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a property holds at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: hdl/dmbe_pkg.sv
// ----------------------------------------------------------------------------
// dmbe_pkg
// Shared types, character codes and helpers of the band encoder.
// ----------------------------------------------------------------------------
package dmbe_pkg;

  localparam int LINE_WORDS_DEF = 32;
  localparam int WORD_BITS_DEF  = 32;
  localparam int BAND_ROWS      = 7;
  localparam int QUEUE_DEPTH    = 2;

  localparam int BYTE_W    = 7;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 8;

  localparam logic [BYTE_W-1:0] CH_STX = 7'h02;
  localparam logic [BYTE_W-1:0] CH_ETX = 7'h03;
  localparam logic [BYTE_W-1:0] CH_SO  = 7'h0E;
  localparam logic [BYTE_W-1:0] CH_ESC = 7'h1B;
  localparam logic [BYTE_W-1:0] CH_A   = 7'h41;
  localparam logic [BYTE_W-1:0] CH_P   = 7'h50;
  localparam logic [BYTE_W-1:0] CH_R   = 7'h52;

  // Position within the printer line
  typedef enum logic [2:0] {
    PH_ESC1,
    PH_A,
    PH_ESC2,
    PH_CMD,
    PH_ETX,
    PH_DATA,
    PH_TAIL
  } phase_e;

  // Back-end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SCAN
  } bk_state_e;

  // Item as held in the queue
  typedef struct packed {
    logic        is_pull;
    logic [2:0]  row;
    logic [4:0]  widx;
    logic [31:0] word;
  } cmd_t;

  // Back-end status towards the top level
  typedef struct packed {
    logic emit;
    logic busy;
  } bk_stat_t;

  // Index of the lowest set bit of a byte (zero when none is set)
  function automatic logic [2:0] tz8(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage

FILE: hdl/dmbe_front.sv
// ----------------------------------------------------------------------------
// dmbe_front
// Accepts input items, drops loads outside the band and queues the rest.
// ----------------------------------------------------------------------------
module dmbe_front import dmbe_pkg::*; #(
  parameter int LINE_WORDS = LINE_WORDS_DEF
) (
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 s_tuser_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output cmd_t                 q_cmd_o
);

  logic in_band;

  assign q_cmd_o.is_pull = s_tuser_i;
  assign q_cmd_o.row     = s_tdata_i[2:0];
  assign q_cmd_o.widx    = s_tdata_i[7:3];
  assign q_cmd_o.word    = s_tdata_i[39:8];

  // drop loads aimed outside the band
  assign in_band = (int'(q_cmd_o.row) < BAND_ROWS) && (int'(q_cmd_o.widx) < LINE_WORDS);

  assign s_tready_o = !q_full_i;
  assign q_push_o   = s_tvalid_i && s_tready_o && (s_tuser_i || in_band);

endmodule

FILE: hdl/dmbe_queue.sv
// ----------------------------------------------------------------------------
// dmbe_queue
// Short first-in first-out queue of items between front and back.
// ----------------------------------------------------------------------------
module dmbe_queue import dmbe_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/dmbe_back.sv
// ----------------------------------------------------------------------------
// dmbe_back
// Executes queued items: band memory writes, rightmost-column tracking and
// byte-by-byte generation of the printer line into an output register.
// ----------------------------------------------------------------------------
module dmbe_back import dmbe_pkg::*; #(
  parameter int LINE_WORDS = LINE_WORDS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hires_i,
  input  logic              q_valid_i,
  input  cmd_t              q_cmd_i,
  output logic              q_pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [BYTE_W-1:0] m_byte_o,
  output logic              m_last_o,
  output bk_stat_t          stat_o
);

  localparam int WIDX_W = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int NGRP   = (WORD_BITS + 7) / 8;
  localparam int PAD_W  = NGRP * 8;

  bk_state_e         bk_q, bk_d;
  phase_e            phase_q, phase_d;
  logic [WIDX_W-1:0] col_w_q, col_w_d;
  logic [BIT_W-1:0]  col_b_q, col_b_d;
  logic [1:0]        tail_q, tail_d;
  logic              pend_q, pend_d;
  logic [WIDX_W-1:0] last_w_q, last_w_d;
  logic [BIT_W-1:0]  last_b_q, last_b_d;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              out_free;

  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  logic              mem_we, mem_re, scan_ld;

  logic [63:0]          word64;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [5:0]           widx6;
  logic [WIDX_W-1:0]    mem_waddr;
  logic [BIT_W-1:0]     bsel;
  logic [BAND_ROWS-1:0] col_code;

  logic [PAD_W-1:0]  scan_word;
  logic [NGRP-1:0]   flag_q;
  logic [2:0]        tz_q [NGRP];
  logic [WIDX_W-1:0] swidx_q;
  logic              scan_found;
  logic [BIT_W-1:0]  scan_off;
  logic              scan_gt;
  logic              at_end;

  assign word64    = {32'b0, q_cmd_i.word};
  assign mem_wdata = word64[WORD_BITS-1:0];
  assign widx6     = {1'b0, q_cmd_i.widx};
  assign mem_waddr = widx6[WIDX_W-1:0];
  assign bsel      = BIT_W'(WORD_BITS - 1) - col_b_q;

  // One memory per band row; a column read fetches the same word of all rows
  for (genvar r = 0; r < BAND_ROWS; r++) begin : g_row
    logic [WORD_BITS-1:0] mem [LINE_WORDS];
    logic [WORD_BITS-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (mem_we && (q_cmd_i.row == 3'(r))) begin
        mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
        rd_q <= mem[col_w_q];
      end
    end
    assign col_code[r] = rd_q[bsel];
  end

  // Rightmost set column of a loaded word: per-byte search, then group pick
  assign scan_word = PAD_W'(mem_wdata);

  always_ff @(posedge clk_i) begin
    if (scan_ld) begin
      for (int g = 0; g < NGRP; g++) begin
        flag_q[g] <= |scan_word[g*8 +: 8];
        tz_q[g]   <= tz8(scan_word[g*8 +: 8]);
      end
      swidx_q <= mem_waddr;
    end
  end

  always_comb begin
    int bi;
    bi = 0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (flag_q[g]) bi = g * 8 + int'(tz_q[g]);
    end
    scan_found = |flag_q;
    scan_off   = BIT_W'(WORD_BITS - 1 - bi);
  end

  assign scan_gt = (swidx_q > last_w_q) || ((swidx_q == last_w_q) && (scan_off > last_b_q));

  assign at_end = (col_w_q > last_w_q)
               || ((col_w_q == last_w_q) && (col_b_q >= last_b_q))
               || ((col_w_q == WIDX_W'(LINE_WORDS - 1)) && (col_b_q == BIT_W'(WORD_BITS - 1)));

  assign out_free = !out_valid_q || m_tready_i;

  // Next state
  always_comb begin
    bk_d = bk_q;
    unique case (bk_q)
      BK_IDLE: begin
        if (q_valid_i && !q_cmd_i.is_pull) begin
          bk_d = BK_SCAN;
        end else if (q_valid_i && out_free && (phase_q == PH_DATA)) begin
          bk_d = BK_FETCH;
        end
      end
      BK_FETCH: bk_d = BK_IDLE;
      BK_SCAN:  bk_d = BK_IDLE;
      default:  bk_d = BK_IDLE;
    endcase
  end

  // Outputs and line state
  always_comb begin
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    scan_ld   = 1'b0;
    emit      = 1'b0;
    emit_byte = CH_ESC;
    emit_last = 1'b0;
    phase_d   = phase_q;
    col_w_d   = col_w_q;
    col_b_d   = col_b_q;
    tail_d    = tail_q;
    pend_d    = pend_q;
    last_w_d  = last_w_q;
    last_b_d  = last_b_q;

    unique case (bk_q)
      BK_IDLE: begin
        if (q_valid_i && !q_cmd_i.is_pull) begin
          q_pop_o = 1'b1;
          mem_we  = 1'b1;
          scan_ld = 1'b1;
        end else if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          unique case (phase_q)
            PH_ESC1: begin
              emit      = 1'b1;
              emit_byte = CH_ESC;
              phase_d   = PH_A;
            end
            PH_A: begin
              emit      = 1'b1;
              emit_byte = CH_A;
              phase_d   = PH_ESC2;
            end
            PH_ESC2: begin
              emit      = 1'b1;
              emit_byte = CH_ESC;
              phase_d   = PH_CMD;
            end
            PH_CMD: begin
              emit      = 1'b1;
              emit_byte = hires_i ? CH_R : CH_P;
              phase_d   = PH_ETX;
            end
            PH_ETX: begin
              emit      = 1'b1;
              emit_byte = CH_ETX;
              phase_d   = PH_DATA;
              col_w_d   = '0;
              col_b_d   = '0;
              pend_d    = 1'b0;
            end
            PH_DATA: begin
              mem_re = 1'b1;
            end
            PH_TAIL: begin
              emit = 1'b1;
              case (tail_q)
                2'd0: begin
                  emit_byte = CH_ETX;
                  tail_d    = 2'd1;
                end
                2'd1: begin
                  emit_byte = CH_SO;
                  tail_d    = 2'd2;
                end
                2'd2: begin
                  emit_byte = CH_ETX;
                  tail_d    = 2'd3;
                end
                default: begin
                  emit_byte = CH_STX;
                  emit_last = 1'b1;
                  phase_d   = PH_ESC1;
                  tail_d    = 2'd0;
                  last_w_d  = '0;
                  last_b_d  = '0;
                end
              endcase
            end
            default: begin
              emit      = 1'b1;
              emit_byte = CH_ESC;
              phase_d   = PH_A;
              col_w_d   = '0;
              col_b_d   = '0;
              tail_d    = 2'd0;
              pend_d    = 1'b0;
            end
          endcase
        end
      end
      BK_FETCH: begin
        emit      = 1'b1;
        emit_byte = col_code;
        if ((col_code == CH_ETX) && !pend_q) begin
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (at_end) begin
            phase_d = PH_TAIL;
            tail_d  = 2'd0;
          end else if (col_b_q == BIT_W'(WORD_BITS - 1)) begin
            col_b_d = '0;
            col_w_d = col_w_q + 1'b1;
          end else begin
            col_b_d = col_b_q + 1'b1;
          end
        end
      end
      BK_SCAN: begin
        if (scan_found && scan_gt) begin
          last_w_d = swidx_q;
          last_b_d = scan_off;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bk_q        <= BK_IDLE;
      phase_q     <= PH_ESC1;
      col_w_q     <= '0;
      col_b_q     <= '0;
      tail_q      <= 2'd0;
      pend_q      <= 1'b0;
      last_w_q    <= '0;
      last_b_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bk_q     <= bk_d;
      phase_q  <= phase_d;
      col_w_q  <= col_w_d;
      col_b_q  <= col_b_d;
      tail_q   <= tail_d;
      pend_q   <= pend_d;
      last_w_q <= last_w_d;
      last_b_q <= last_b_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign m_tvalid_o  = out_valid_q;
  assign m_byte_o    = out_byte_q;
  assign m_last_o    = out_last_q;
  assign stat_o.emit = emit;
  assign stat_o.busy = (bk_q != BK_IDLE);

endmodule

FILE: hdl/dot_matrix_band_encoder.sv
// ----------------------------------------------------------------------------
// dot_matrix_band_encoder
// Band raster store and printer line generator for a seven-row print head.
// ----------------------------------------------------------------------------
// Load items (tuser low) write one raster word of one band row; the most
// significant bit of a word is the leftmost column, and loads with a row of
// seven or more or a word index past the line are dropped. Pull items (tuser
// high) each return one byte of the printer line: ESC A, ESC P (ESC R when
// hires is set), ETX, then one seven-bit column code per column from the left
// up to the rightmost column loaded with a set bit since the last line ended
// (at least one column, an ETX code sent twice), then ETX SO ETX STX, with
// tlast on the STX. After the STX the line state starts over; the band words
// stay. Input items enter a two-entry queue and are accepted every cycle
// while it has room. The back end handles a load with the memory write, then
// the rightmost-column search over byte groups; a column pull reads the band
// memory into a register before its byte goes out, and every other pull sends
// its byte straight from the idle state. A result waits in the output register
// while the back end goes on with loads. Write hires only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dot_matrix_band_encoder import dmbe_pkg::*; #(
  parameter int LINE_WORDS = LINE_WORDS_DEF,  // words per band row, 1 to 64
  parameter int WORD_BITS  = WORD_BITS_DEF    // bits per raster word, 8 to 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // hires register: 1 selects 144 dpi
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // row[2:0], word_index[7:3], word[39:8]
  input  logic                 s_axis_tuser,  // func: 0 load, 1 pull
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // out_byte[6:0], zero[7]
  output logic                 m_axis_tlast   // last: final STX of the line
);

  logic              hires_q;
  logic              q_push, q_full, q_pop, q_valid;
  cmd_t              q_in, q_out;
  logic [BYTE_W-1:0] out_byte;
  bk_stat_t          bk_stat;

  // Hold the plot resolution; read when the plot command byte goes out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hires_q <= 1'b0;
    end else if (cfg_we_i) begin
      hires_q <= cfg_wdata_i;
    end
  end

  // Classify and drop out-of-band loads
  dmbe_front #(
    .LINE_WORDS(LINE_WORDS)
  ) u_front (
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_in)
  );

  // Decouple the input side from the back end
  dmbe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  // Execute items and drive the output register
  dmbe_back #(
    .LINE_WORDS(LINE_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hires_i   (hires_q),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_out),
    .q_pop_o   (q_pop),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_byte_o  (out_byte),
    .m_last_o  (m_axis_tlast),
    .stat_o    (bk_stat)
  );

  assign m_axis_tdata = {1'b0, out_byte};

  // Assertions
  `ASSERT_NEVER(a_queue_no_overflow, q_push && q_full, "push into a full queue")
  `ASSERT_NEVER(a_queue_no_underflow, q_pop && !q_valid, "pop from an empty queue")
  `ASSERT_NEVER(a_out_no_overwrite, bk_stat.emit && m_axis_tvalid && !m_axis_tready,
                "result overwritten before it was taken")
  `ASSERT_NEVER(a_pop_only_idle, bk_stat.busy && q_pop, "queue popped mid-item")
  `ASSERT_CLK(a_last_is_stx, (m_axis_tvalid && m_axis_tlast) |-> (out_byte == CH_STX),
              "line end flagged on a byte other than STX")

endmodule
